### rtl/scv_pkg.sv
// ---------------------------------------------------------------------------
// scv_pkg
// Shared widths, flag positions, register indexes and helpers for the sprite
// clip and variant select block.
// ---------------------------------------------------------------------------
package scv_pkg;

   // field widths
   localparam int FLAGS_W     = 6;
   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 12;
   localparam int EXT_W       = 18;
   localparam int INDEX_W     = 15;
   localparam int VAR_W       = 21;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 112;

   // mode flag bit positions
   localparam int FLAG_ABSOLUTE   = 0;
   localparam int FLAG_CLIP_SELF  = 1;
   localparam int FLAG_SCROLL1    = 2;
   localparam int FLAG_SCROLL4    = 3;
   localparam int FLAG_LEFT_EDGE  = 4;
   localparam int FLAG_RIGHT_EDGE = 5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // register reset values
   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   // saturation limits in the extended width
   localparam logic signed [EXT_W-1:0]   COORD_MAX = 18'sd32767;
   localparam logic signed [EXT_W-1:0]   COORD_MIN = -18'sd32768;
   localparam logic [VAR_W-1:0]          INDEX_MAX = 21'd32767;

   // one primitive node as taken from the request
   typedef struct packed {
      logic [FLAGS_W-1:0]        mode_flags;
      logic signed [COORD_W-1:0] rel_x;
      logic signed [COORD_W-1:0] rel_y;
      logic [SIZE_W-1:0]         item_width;
      logic [SIZE_W-1:0]         item_height;
      logic signed [COORD_W-1:0] parent_abs_x;
      logic signed [COORD_W-1:0] parent_abs_y;
      logic signed [COORD_W-1:0] view_left;
      logic signed [COORD_W-1:0] view_top;
      logic signed [COORD_W-1:0] view_right;
      logic signed [COORD_W-1:0] view_bottom;
   } node_type;

   // clipped geometry handed to the variant selector and the result register
   typedef struct packed {
      logic signed [COORD_W-1:0] abs_x;
      logic signed [COORD_W-1:0] abs_y;
      logic signed [COORD_W-1:0] draw_left;
      logic signed [COORD_W-1:0] draw_top;
      logic signed [COORD_W-1:0] draw_right;
      logic signed [COORD_W-1:0] draw_bottom;
      logic                      is_visible;
      logic [EXT_W-1:0]          left_hide;
      logic [EXT_W-1:0]          right_hide;
   } clip_type;

   // sign extend a coordinate to the extended width
   function automatic logic signed [EXT_W-1:0] sext_coord(
      input logic signed [COORD_W-1:0] v);
      return $signed({{(EXT_W-COORD_W){v[COORD_W-1]}}, v});
   endfunction

   // clamp an extended value to a 16 bit coordinate
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [EXT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > COORD_MAX) begin
         r = 16'sh7FFF;
      end else if (v < COORD_MIN) begin
         r = 16'sh8000;
      end else begin
         r = $signed(v[COORD_W-1:0]);
      end
      return r;
   endfunction

   // hidden pixels in groups of four, first group at zero
   function automatic logic [VAR_W-1:0] quarter_minus_one(
      input logic [EXT_W-1:0] h);
      logic [EXT_W-3:0] q;
      logic [VAR_W-1:0] r;
      q = h[EXT_W-1:2];
      if (q != '0) begin
         r = VAR_W'(q - 1'b1);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

### rtl/scv_geom.sv
// ---------------------------------------------------------------------------
// scv_geom
// Absolute position, extents and clipping of one node against the inherited
// window or the full screen.
// ---------------------------------------------------------------------------
module scv_geom
   import scv_pkg::*;
(
   input  node_type          node,
   input  logic [SIZE_W-1:0] screen_width,
   input  logic [SIZE_W-1:0] screen_height,
   output clip_type          clip
);

   logic signed [COORD_W-1:0] ax;
   logic signed [COORD_W-1:0] ay;
   logic signed [EXT_W-1:0]   ax_e;
   logic signed [EXT_W-1:0]   ay_e;
   logic signed [EXT_W-1:0]   xe;
   logic signed [EXT_W-1:0]   ye;
   logic signed [EXT_W-1:0]   vl;
   logic signed [EXT_W-1:0]   vt;
   logic signed [EXT_W-1:0]   vr;
   logic signed [EXT_W-1:0]   vb;
   logic signed [EXT_W-1:0]   dl;
   logic signed [EXT_W-1:0]   dt;
   logic signed [EXT_W-1:0]   dr;
   logic signed [EXT_W-1:0]   db;
   logic [EXT_W-1:0]          left_cnt;
   logic [EXT_W-1:0]          right_cnt;

   // absolute position, saturated when relative
   always_comb begin
      if (node.mode_flags[FLAG_ABSOLUTE]) begin
         ax = node.rel_x;
         ay = node.rel_y;
      end else begin
         ax = sat_coord(sext_coord(node.parent_abs_x) + sext_coord(node.rel_x));
         ay = sat_coord(sext_coord(node.parent_abs_y) + sext_coord(node.rel_y));
      end
   end

   // exclusive extents
   assign ax_e = sext_coord(ax);
   assign ay_e = sext_coord(ay);
   assign xe   = ax_e + $signed({{(EXT_W-SIZE_W){1'b0}}, node.item_width});
   assign ye   = ay_e + $signed({{(EXT_W-SIZE_W){1'b0}}, node.item_height});

   // clip window: inherited or full screen
   always_comb begin
      if (node.mode_flags[FLAG_CLIP_SELF]) begin
         vl = sext_coord(node.view_left);
         vt = sext_coord(node.view_top);
         vr = sext_coord(node.view_right);
         vb = sext_coord(node.view_bottom);
      end else begin
         vl = '0;
         vt = '0;
         vr = $signed({{(EXT_W-SIZE_W){1'b0}}, screen_width});
         vb = $signed({{(EXT_W-SIZE_W){1'b0}}, screen_height});
      end
   end

   // intersect with the window
   assign dl = (ax_e > vl) ? ax_e : vl;
   assign dt = (ay_e > vt) ? ay_e : vt;
   assign dr = (xe < vr) ? xe : vr;
   assign db = (ye < vb) ? ye : vb;

   // hidden pixels, left edge first
   always_comb begin
      left_cnt  = '0;
      right_cnt = '0;
      if (ax_e < dl) begin
         left_cnt = dl - ax_e;
      end else if (dr < xe) begin
         right_cnt = xe - dr;
      end
   end

   // saturated outputs and visibility from the unsaturated edges
   assign clip.abs_x       = ax;
   assign clip.abs_y       = ay;
   assign clip.draw_left   = sat_coord(dl);
   assign clip.draw_top    = sat_coord(dt);
   assign clip.draw_right  = sat_coord(dr);
   assign clip.draw_bottom = sat_coord(db);
   assign clip.is_visible  = (dr > dl) && (db > dt);
   assign clip.left_hide   = left_cnt;
   assign clip.right_hide  = right_cnt;

endmodule

### rtl/scv_variant.sv
// ---------------------------------------------------------------------------
// scv_variant
// Paint variant index from the scroll mode, the hidden edge pixels and the
// pixel phase, counted in generation order and saturated to 15 bits.
// ---------------------------------------------------------------------------
module scv_variant
   import scv_pkg::*;
(
   input  logic [FLAGS_W-1:0] mode_flags,
   input  logic [SIZE_W-1:0]  item_width,
   input  logic [1:0]         pos,
   input  logic [EXT_W-1:0]   left_hide,
   input  logic [EXT_W-1:0]   right_hide,
   output logic [INDEX_W-1:0] variant_index
);

   logic [SIZE_W-1:0] wm1;
   logic [VAR_W-1:0]  group1;
   logic [VAR_W-1:0]  group4;
   logic [VAR_W-1:0]  fine_l;
   logic [VAR_W-1:0]  fine_r;
   logic [VAR_W-1:0]  coarse_l;
   logic [VAR_W-1:0]  coarse_r;
   logic [VAR_W-1:0]  pos_e;
   logic [VAR_W-1:0]  base;
   logic [VAR_W-1:0]  idx;
   logic              le;
   logic              re;

   assign le = mode_flags[FLAG_LEFT_EDGE];
   assign re = mode_flags[FLAG_RIGHT_EDGE];

   // group sizes for the two scroll modes
   assign wm1    = (item_width != '0) ? item_width - 1'b1 : '0;
   assign group1 = VAR_W'({wm1, 2'b00});
   assign group4 = VAR_W'(wm1[SIZE_W-1:2]);
   assign pos_e  = VAR_W'(pos);

   // offsets within the left and right groups
   assign fine_l   = VAR_W'({left_hide - 1'b1, 2'b00}) + pos_e;
   assign fine_r   = VAR_W'({right_hide - 1'b1, 2'b00}) + pos_e;
   assign coarse_l = quarter_minus_one(left_hide);
   assign coarse_r = quarter_minus_one(right_hide);

   // walk the groups in generation order
   always_comb begin
      base = '0;
      idx  = '0;
      priority if (mode_flags[FLAG_SCROLL1]) begin
         if (le && left_hide != '0) begin
            idx = fine_l;
         end else begin
            base = le ? group1 : '0;
            if (re && right_hide != '0) begin
               idx = base + fine_r;
            end else begin
               idx = base + (re ? group1 : '0) + pos_e;
            end
         end
      end else if (mode_flags[FLAG_SCROLL4]) begin
         if (le && left_hide != '0) begin
            idx = coarse_l;
         end else begin
            base = le ? group4 : '0;
            if (re && right_hide != '0) begin
               idx = base + coarse_r;
            end else begin
               idx = base + (re ? group4 : '0);
            end
         end
      end else begin
         idx = '0;
      end
   end

   // saturate
   assign variant_index = (idx > INDEX_MAX) ? {INDEX_W{1'b1}} : idx[INDEX_W-1:0];

endmodule

### rtl/sprite_clip_and_variant_select_core.sv
// ---------------------------------------------------------------------------
// sprite_clip_and_variant_select_core
// Clips one display primitive node per cycle unless stalled and picks its paint variant.
// ---------------------------------------------------------------------------
// Each request holds one primitive node and gives exactly one response. The
// node is captured in an input register, clipped and its paint variant chosen
// in one pass of adds and compares, and the answer held in a result register;
// a request goes from the input register to the result register, and a new one
// is taken every cycle while the response side keeps up. The screen size
// registers (index 0 width, index 1 height, reset 640 by 480) are the clip
// window for nodes that do not clip to their inherited window; write them only
// while no request is in flight. Writes to other indexes are dropped.
module sprite_clip_and_variant_select_core
   import scv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rel_x[15:0], rel_y[31:16], item_width[43:32], item_height[55:44],
   // parent_abs_x[71:56], parent_abs_y[87:72], view_left[103:88],
   // view_top[119:104], view_right[135:120], view_bottom[151:136]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode_flags[5:0]
   input  logic [FLAGS_W-1:0]     req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // abs_x[15:0], abs_y[31:16], draw_left[47:32], draw_top[63:48],
   // draw_right[79:64], draw_bottom[95:80], is_visible[96],
   // variant_index[111:97]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]      csr_data
);

   logic [SIZE_W-1:0]      screen_width_ff;
   logic [SIZE_W-1:0]      screen_width_in;
   logic [SIZE_W-1:0]      screen_height_ff;
   logic [SIZE_W-1:0]      screen_height_in;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   node_type               in_node_ff;
   node_type               in_node_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic [RSP_TDATA_W-1:0] out_data_in;
   logic                   req_take;
   logic                   out_load;
   clip_type               clip;
   logic [INDEX_W-1:0]     variant_index;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_data;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // pipeline flow control
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   // unpack the request
   always_comb begin
      in_node_in.mode_flags   = req_tuser;
      in_node_in.rel_x        = $signed(req_tdata[15:0]);
      in_node_in.rel_y        = $signed(req_tdata[31:16]);
      in_node_in.item_width   = req_tdata[43:32];
      in_node_in.item_height  = req_tdata[55:44];
      in_node_in.parent_abs_x = $signed(req_tdata[71:56]);
      in_node_in.parent_abs_y = $signed(req_tdata[87:72]);
      in_node_in.view_left    = $signed(req_tdata[103:88]);
      in_node_in.view_top     = $signed(req_tdata[119:104]);
      in_node_in.view_right   = $signed(req_tdata[135:120]);
      in_node_in.view_bottom  = $signed(req_tdata[151:136]);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_node_ff <= in_node_in;
      end
   end

   // clipping
   scv_geom u_geom (
      .node          (in_node_ff),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .clip          (clip)
   );

   // variant selection
   scv_variant u_variant (
      .mode_flags    (in_node_ff.mode_flags),
      .item_width    (in_node_ff.item_width),
      .pos           (clip.abs_x[1:0]),
      .left_hide     (clip.left_hide),
      .right_hide    (clip.right_hide),
      .variant_index (variant_index)
   );

   // pack the response
   assign out_data_in = {variant_index, clip.is_visible,
                         clip.draw_bottom, clip.draw_right,
                         clip.draw_top, clip.draw_left,
                         clip.abs_y, clip.abs_x};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   // a node leaving the input register shows up as a response
   a_load_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   // a visible rectangle never has inverted edges
   a_visible_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[96] |->
         ($signed(rsp_tdata[79:64]) >= $signed(rsp_tdata[47:32])) &&
         ($signed(rsp_tdata[95:80]) >= $signed(rsp_tdata[63:48])))
      else $error("visible rectangle with inverted edges");

   // without a scroll mode the variant index is zero
   a_no_scroll_index: assert property (@(posedge clock) disable iff (reset)
      out_load && !in_node_ff.mode_flags[FLAG_SCROLL1] &&
         !in_node_ff.mode_flags[FLAG_SCROLL4] |=> rsp_tdata[111:97] == '0)
      else $error("variant index set without scroll mode");

   // absolute nodes keep their own position
   a_absolute_pos: assert property (@(posedge clock) disable iff (reset)
      out_load && in_node_ff.mode_flags[FLAG_ABSOLUTE] |=>
         rsp_tdata[15:0] == $past(in_node_ff.rel_x))
      else $error("absolute node position altered");
`endif

endmodule
